FILE: src/ceu_pkg.sv
`default_nettype none

package ceu_pkg;

    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_X         = 8'h78;
    localparam logic [7:0] CHAR_N         = 8'h6E;
    localparam logic [7:0] CHAR_T         = 8'h74;
    localparam logic [7:0] CHAR_V         = 8'h76;
    localparam logic [7:0] CHAR_B         = 8'h62;
    localparam logic [7:0] CHAR_R         = 8'h72;
    localparam logic [7:0] CHAR_F         = 8'h66;
    localparam logic [7:0] CHAR_A         = 8'h61;
    localparam logic [7:0] CHAR_DQUOTE    = 8'h22;
    localparam logic [7:0] CHAR_SQUOTE    = 8'h27;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;

    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_BEL = 8'h07;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       run_last;
        logic       string_end;
    } out_word_t;

    typedef struct packed {
        logic       two;
        logic [7:0] first;
        logic [7:0] second;
        logic       last;
    } entry_t;

    typedef struct packed {
        logic   push;
        entry_t entry;
    } front_push_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } escape_t;

    typedef struct packed {
        logic       hit;
        logic [3:0] value;
    } hex_t;

    function automatic escape_t simple_escape(input logic [7:0] b);
        escape_t r;
        r.hit   = 1'b1;
        r.value = b;
        case (b)
            CHAR_BACKSLASH: r.value = CHAR_BACKSLASH;
            CHAR_N:         r.value = CODE_LF;
            CHAR_T:         r.value = CODE_TAB;
            CHAR_V:         r.value = CODE_VT;
            CHAR_B:         r.value = CODE_BS;
            CHAR_R:         r.value = CODE_CR;
            CHAR_F:         r.value = CODE_FF;
            CHAR_A:         r.value = CODE_BEL;
            CHAR_DQUOTE:    r.value = CHAR_DQUOTE;
            CHAR_SQUOTE:    r.value = CHAR_SQUOTE;
            default:        r.hit   = 1'b0;
        endcase
        return r;
    endfunction

    function automatic hex_t hex_digit(input logic [7:0] b);
        hex_t r;
        r.hit   = 1'b1;
        r.value = b[3:0];
        case (b) inside
            [8'h30:8'h39]:                r.value = b[3:0];
            [8'h41:8'h46], [8'h61:8'h66]: r.value = b[3:0] + 4'd9;
            default:                      r.hit   = 1'b0;
        endcase
        return r;
    endfunction

    function automatic logic is_octal(input logic [7:0] b);
        logic r;
        r = 1'b0;
        case (b) inside
            [8'h30:8'h37]: r = 1'b1;
            default:       r = 1'b0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/c_escape_unescaper_unit.sv
// C string escape decoder.
// Input channel: drive src (in_byte, in_last) with push; a word is taken at a
// rising edge where push is high and full is low. One source byte can be taken
// every cycle while full is low. Bytes carry the body of a C string literal;
// in_last marks the final byte of a string.
// Result channel: while empty is low, dst holds the oldest decoded byte; it is
// taken at a rising edge where pop is high. run_last marks the final word made
// from one source byte, string_end the final word of the string.
// A source byte yields zero, one or two words; a word enters the queue when
// the byte that made it is taken. The output side moves one word per cycle
// while pop is high, so a byte that makes two words needs two pops.
// A queue of QueueDepth entries, one per producing byte, parts the decoder from
// the output side; when pop stays low the queue fills and full rises, holding
// the input until space frees up. Sustained input rate is one byte per cycle
// as long as the queue has space.
// Reset empties the queue and returns the decoder to normal scanning.
`default_nettype none

module c_escape_unescaper_unit #(
    parameter int QueueDepth = ceu_pkg::QUEUE_DEPTH
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    output logic                   full,
    input  wire ceu_pkg::in_word_t src,
    output logic                   empty,
    input  wire logic              pop,
    output ceu_pkg::out_word_t     dst
);

    ceu_pkg::front_push_t to_queue;
    ceu_pkg::entry_t      head;
    logic                 q_empty;
    logic                 deq;

    ceu_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .src        (src),
        .queue_full (full),
        .to_queue   (to_queue)
    );

    ceu_queue #(
        .Depth (QueueDepth)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .from_front (to_queue),
        .deq        (deq),
        .q_full     (full),
        .q_empty    (q_empty),
        .head       (head)
    );

    ceu_back u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .head    (head),
        .q_empty (q_empty),
        .pop     (pop),
        .deq     (deq),
        .empty   (empty),
        .dst     (dst)
    );

endmodule

`default_nettype wire

FILE: src/ceu_front.sv
`default_nettype none

module ceu_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire ceu_pkg::in_word_t src,
    input  wire logic              queue_full,
    output ceu_pkg::front_push_t   to_queue
);

    typedef enum logic [3:0] {
        ST_NORMAL = 4'b0001,
        ST_ESCAPE = 4'b0010,
        ST_HEX    = 4'b0100,
        ST_OCTAL  = 4'b1000
    } scan_state_t;

    scan_state_t mode_reg, mode_next;
    logic [7:0]  value_reg, value_next;

    logic            accept;
    logic [1:0]      cnt;
    logic [7:0]      b;
    logic            last;
    ceu_pkg::escape_t esc;
    ceu_pkg::hex_t    hex;
    ceu_pkg::entry_t  entry;

    assign accept = push && !queue_full;
    assign b      = src.in_byte;
    assign last   = src.in_last;
    assign esc    = ceu_pkg::simple_escape(b);
    assign hex    = ceu_pkg::hex_digit(b);

    always_comb
    begin
        cnt          = 2'd0;
        entry.two    = 1'b0;
        entry.first  = b;
        entry.second = b;
        entry.last   = last;
        mode_next    = mode_reg;
        value_next   = value_reg;
        case (mode_reg)
            ST_NORMAL:
            begin
                if (b == ceu_pkg::CHAR_BACKSLASH && !last)
                begin
                    mode_next = ST_ESCAPE;
                end
                else
                begin
                    cnt = 2'd1;
                end
            end
            ST_ESCAPE:
            begin
                mode_next = ST_NORMAL;
                if (esc.hit)
                begin
                    cnt         = 2'd1;
                    entry.first = esc.value;
                end
                else if (b == ceu_pkg::CHAR_X)
                begin
                    value_next = 8'd0;
                    if (last)
                    begin
                        cnt         = 2'd1;
                        entry.first = 8'd0;
                    end
                    else
                    begin
                        mode_next = ST_HEX;
                    end
                end
                else if (ceu_pkg::is_octal(b))
                begin
                    value_next = {5'd0, b[2:0]};
                    if (last)
                    begin
                        cnt         = 2'd1;
                        entry.first = {5'd0, b[2:0]};
                    end
                    else
                    begin
                        mode_next = ST_OCTAL;
                    end
                end
                else
                begin
                    cnt          = 2'd2;
                    entry.first  = ceu_pkg::CHAR_BACKSLASH;
                    entry.second = b;
                end
            end
            ST_HEX, ST_OCTAL:
            begin
                if ((mode_reg == ST_HEX) ? hex.hit : ceu_pkg::is_octal(b))
                begin
                    value_next = (mode_reg == ST_HEX) ? {value_reg[3:0], hex.value}
                                                      : {value_reg[4:0], b[2:0]};
                    if (last)
                    begin
                        cnt         = 2'd1;
                        entry.first = value_next;
                        mode_next   = ST_NORMAL;
                    end
                end
                else
                begin
                    entry.first = value_reg;
                    if (b == ceu_pkg::CHAR_BACKSLASH && !last)
                    begin
                        cnt       = 2'd1;
                        mode_next = ST_ESCAPE;
                    end
                    else
                    begin
                        cnt       = 2'd2;
                        mode_next = ST_NORMAL;
                    end
                end
            end
            default:
            begin
                mode_next = ST_NORMAL;
            end
        endcase
        if (last)
        begin
            mode_next  = ST_NORMAL;
            value_next = 8'd0;
        end
        entry.two = (cnt == 2'd2);
    end

    assign to_queue.push  = accept && (cnt != 2'd0);
    assign to_queue.entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= ST_NORMAL;
            value_reg <= 8'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            value_reg <= value_next;
        end
    end

    a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |-> to_queue.push)
        else $error("end of string produced no word");

    a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && last) |=> (mode_reg == ST_NORMAL && value_reg == 8'd0))
        else $error("scan state not cleared after end of string");

endmodule

`default_nettype wire

FILE: src/ceu_queue.sv
`default_nettype none

module ceu_queue #(
    parameter int Depth = ceu_pkg::QUEUE_DEPTH
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire ceu_pkg::front_push_t from_front,
    input  wire logic                 deq,
    output logic                      q_full,
    output logic                      q_empty,
    output ceu_pkg::entry_t           head
);

    localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int CntW = $clog2(Depth + 1);

    ceu_pkg::entry_t mem_reg [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_push, do_pop;

    assign q_full  = (count_reg == CntW'(Depth));
    assign q_empty = (count_reg == '0);
    assign head    = mem_reg[rd_ptr_reg];
    assign do_push = from_front.push && !q_full;
    assign do_pop  = deq && !q_empty;

    function automatic logic [PtrW-1:0] bump(input logic [PtrW-1:0] p);
        return (p == PtrW'(Depth - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= from_front.entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= bump(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= bump(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CntW'(Depth))
        else $error("queue count past depth");

endmodule

`default_nettype wire

FILE: src/ceu_back.sv
`default_nettype none

module ceu_back (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire ceu_pkg::entry_t head,
    input  wire logic            q_empty,
    input  wire logic            pop,
    output logic                 deq,
    output logic                 empty,
    output ceu_pkg::out_word_t   dst
);

    logic second_reg;
    logic final_word;
    logic take;

    assign empty          = q_empty;
    assign take           = pop && !q_empty;
    assign final_word     = second_reg || !head.two;
    assign dst.out_byte   = second_reg ? head.second : head.first;
    assign dst.run_last   = final_word;
    assign dst.string_end = final_word && head.last;
    assign deq            = take && final_word;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            second_reg <= 1'b0;
        end
        else if (take)
        begin
            second_reg <= !final_word;
        end
    end

    a_second_valid: assert property (@(posedge clk) disable iff (!rst_n)
        second_reg |-> (!q_empty && head.two))
        else $error("second word selected without a two-word entry");

endmodule

`default_nettype wire
